[rtl/core/shape_pixel_coverage_test_unit_defines.svh]
// ----------------------------------------------------------------------------
// Shape pixel coverage test unit - assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SHAPE_PIXEL_COVERAGE_TEST_UNIT_DEFINES_SVH
`define SHAPE_PIXEL_COVERAGE_TEST_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SPCT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/spct_pkg.sv]
// ----------------------------------------------------------------------------
// Shape pixel coverage test - package
// Widths, register indexes, shape codes, pipeline payload types and helpers.
// ----------------------------------------------------------------------------
package spct_pkg;

    localparam int COORD_BITS  = 12;
    localparam int VTX_W       = 2 * COORD_BITS;
    localparam int PIX_W       = 11;
    localparam int IMG_W       = 12;
    localparam int RAD_W       = 11;
    localparam int COL_W       = 24;
    localparam int CH_W        = 8;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DW      = (VTX_W > COL_W) ? VTX_W : COL_W;

    // Signed width holding a pixel, a vertex coordinate, their difference
    // and a circle bound (center plus or minus radius).
    localparam int WD_W        = ((COORD_BITS > PIX_W + 1) ? COORD_BITS : PIX_W + 1) + 1;
    localparam int VD_W        = COORD_BITS + 1;
    localparam int EP_W        = VD_W + WD_W;
    localparam int ES_W        = EP_W + 1;
    localparam int ST_W        = ES_W + 1;
    localparam int SQ_W        = 2 * WD_W;
    localparam int DS_W        = SQ_W + 1;
    localparam int R2_W        = 2 * RAD_W;

    localparam int IN_TDATA_W  = ((2 * PIX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * PIX_W + COL_W + 7) / 8) * 8;

    localparam logic [IMG_W-1:0] IMG_SIZE_RST = IMG_W'(2048);

    localparam logic [KIND_W-1:0] KIND_TRI    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CIRCLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd7;

    typedef struct packed {
        logic [KIND_W-1:0] shape_kind;
        logic [COL_W-1:0]  fill_color;
        logic [VTX_W-1:0]  vertex_a;
        logic [VTX_W-1:0]  vertex_b;
        logic [VTX_W-1:0]  vertex_c;
        logic [RAD_W-1:0]  radius;
        logic [IMG_W-1:0]  image_width;
        logic [IMG_W-1:0]  image_height;
    } t_cfg;

    // Operands of one edge function: ex*qy - ey*qx.
    typedef struct packed {
        logic signed [VD_W-1:0] ex;
        logic signed [VD_W-1:0] ey;
        logic signed [WD_W-1:0] qx;
        logic signed [WD_W-1:0] qy;
    } t_edge_op;

    typedef struct packed {
        logic [PIX_W-1:0]  px;
        logic [PIX_W-1:0]  py;
        logic [KIND_W-1:0] kind;
        logic              box_ok;
        logic              rect_hit;
        t_edge_op          e0;
        t_edge_op          e1;
        t_edge_op          e2;
    } t_setup;

    typedef struct packed {
        logic [PIX_W-1:0]       px;
        logic [PIX_W-1:0]       py;
        logic [KIND_W-1:0]      kind;
        logic                   box_ok;
        logic                   rect_hit;
        logic signed [EP_W-1:0] p0a;
        logic signed [EP_W-1:0] p0b;
        logic signed [EP_W-1:0] p1a;
        logic signed [EP_W-1:0] p1b;
        logic signed [EP_W-1:0] p2a;
        logic signed [EP_W-1:0] p2b;
        logic [SQ_W-1:0]        dx2;
        logic [SQ_W-1:0]        dy2;
        logic [R2_W-1:0]        r2;
    } t_prod;

    typedef struct packed {
        logic [PIX_W-1:0]       px;
        logic [PIX_W-1:0]       py;
        logic [KIND_W-1:0]      kind;
        logic                   box_ok;
        logic                   rect_hit;
        logic                   circ_hit;
        logic signed [ES_W-1:0] s;
        logic signed [ES_W-1:0] t;
        logic signed [ES_W-1:0] d;
    } t_edge;

    typedef struct packed {
        logic             we;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
    } t_result;

    function automatic logic signed [COORD_BITS-1:0] coord_x(input logic [VTX_W-1:0] v);
        return $signed(v[VTX_W-1:COORD_BITS]);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] coord_y(input logic [VTX_W-1:0] v);
        return $signed(v[COORD_BITS-1:0]);
    endfunction

    function automatic logic signed [WD_W-1:0] to_wd(input logic signed [COORD_BITS-1:0] c);
        return WD_W'(c);
    endfunction

    function automatic logic signed [WD_W-1:0] pix_wd(input logic [PIX_W-1:0] p);
        return $signed(WD_W'(p));
    endfunction

    // Edge from vertex va to vb, evaluated at the pixel.
    function automatic t_edge_op edge_op(input logic [VTX_W-1:0] va,
                                         input logic [VTX_W-1:0] vb,
                                         input logic [PIX_W-1:0] px,
                                         input logic [PIX_W-1:0] py);
        t_edge_op e;
        e.ex = VD_W'(coord_x(va)) - VD_W'(coord_x(vb));
        e.ey = VD_W'(coord_y(va)) - VD_W'(coord_y(vb));
        e.qx = pix_wd(px) - to_wd(coord_x(vb));
        e.qy = pix_wd(py) - to_wd(coord_y(vb));
        return e;
    endfunction

endpackage

[rtl/core/spct_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Shape pixel coverage test - configuration registers
// Holds the shape, color, vertices, radius and image size.
// ----------------------------------------------------------------------------
module spct_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [spct_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [spct_pkg::CFG_DW-1:0]       i_data,
    output spct_pkg::t_cfg                    o_cfg
);
    import spct_pkg::*;

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // Mask each write to its register width; drop unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shape_kind   <= KIND_TRI;
            r_cfg.fill_color   <= '0;
            r_cfg.vertex_a     <= '0;
            r_cfg.vertex_b     <= '0;
            r_cfg.vertex_c     <= '0;
            r_cfg.radius       <= '0;
            r_cfg.image_width  <= IMG_SIZE_RST;
            r_cfg.image_height <= IMG_SIZE_RST;
        end else if (i_valid) begin
            case (i_index)
                REG_SHAPE_KIND:   r_cfg.shape_kind   <= i_data[KIND_W-1:0];
                REG_FILL_COLOR:   r_cfg.fill_color   <= i_data[COL_W-1:0];
                REG_VERTEX_A:     r_cfg.vertex_a     <= i_data[VTX_W-1:0];
                REG_VERTEX_B:     r_cfg.vertex_b     <= i_data[VTX_W-1:0];
                REG_VERTEX_C:     r_cfg.vertex_c     <= i_data[VTX_W-1:0];
                REG_RADIUS:       r_cfg.radius       <= i_data[RAD_W-1:0];
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_data[IMG_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= i_data[IMG_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/core/spct_setup.sv]
// ----------------------------------------------------------------------------
// Shape pixel coverage test - setup stage
// Bounding box, clip and rectangle tests; edge operand differences.
// ----------------------------------------------------------------------------
module spct_setup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spct_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [spct_pkg::PIX_W-1:0]    i_px,
    input  logic [spct_pkg::PIX_W-1:0]    i_py,
    output logic                          o_valid,
    input  logic                          i_ready,
    output spct_pkg::t_setup              o_data
);
    import spct_pkg::*;

    logic                   r_valid;
    t_setup                 r_data;
    t_setup                 n_data;

    logic signed [WD_W-1:0] ax, ay, bx, by, cx, cy, rad, pxs, pys;
    logic signed [WD_W-1:0] lx, hx, ly, hy;
    logic                   kind_ok, in_box, in_img;

    function automatic logic signed [WD_W-1:0] min3(input logic signed [WD_W-1:0] a,
                                                    input logic signed [WD_W-1:0] b,
                                                    input logic signed [WD_W-1:0] c);
        logic signed [WD_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [WD_W-1:0] max3(input logic signed [WD_W-1:0] a,
                                                    input logic signed [WD_W-1:0] b,
                                                    input logic signed [WD_W-1:0] c);
        logic signed [WD_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    always_comb begin
        ax  = to_wd(coord_x(i_cfg.vertex_a));
        ay  = to_wd(coord_y(i_cfg.vertex_a));
        bx  = to_wd(coord_x(i_cfg.vertex_b));
        by  = to_wd(coord_y(i_cfg.vertex_b));
        cx  = to_wd(coord_x(i_cfg.vertex_c));
        cy  = to_wd(coord_y(i_cfg.vertex_c));
        rad = $signed(WD_W'(i_cfg.radius));
        pxs = pix_wd(i_px);
        pys = pix_wd(i_py);

        kind_ok = 1'b1;
        case (i_cfg.shape_kind)
            KIND_TRI: begin
                lx = min3(ax, bx, cx);
                hx = max3(ax, bx, cx);
                ly = min3(ay, by, cy);
                hy = max3(ay, by, cy);
            end
            KIND_CIRCLE: begin
                lx = ax - rad;
                hx = ax + rad;
                ly = ay - rad;
                hy = ay + rad;
            end
            KIND_RECT: begin
                lx = ax;
                hx = bx;
                ly = ay;
                hy = by;
            end
            default: begin
                lx      = '0;
                hx      = '0;
                ly      = '0;
                hy      = '0;
                kind_ok = 1'b0;
            end
        endcase

        in_box = (pxs >= lx) && (pxs < hx) && (pys >= ly) && (pys < hy);
        in_img = (IMG_W'(i_px) < i_cfg.image_width) && (IMG_W'(i_py) < i_cfg.image_height);

        n_data.px       = i_px;
        n_data.py       = i_py;
        n_data.kind     = i_cfg.shape_kind;
        n_data.box_ok   = kind_ok && in_box && in_img;
        n_data.rect_hit = (pxs > ax) && (pxs < bx) && (pys > ay) && (pys < by);
        n_data.e0       = edge_op(i_cfg.vertex_a, i_cfg.vertex_c, i_px, i_py);
        n_data.e1       = edge_op(i_cfg.vertex_b, i_cfg.vertex_a, i_px, i_py);
        n_data.e2       = edge_op(i_cfg.vertex_c, i_cfg.vertex_b, i_px, i_py);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

[rtl/core/spct_mul.sv]
// ----------------------------------------------------------------------------
// Shape pixel coverage test - multiply stage
// Edge function products, squared distances and squared radius.
// ----------------------------------------------------------------------------
module spct_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [spct_pkg::RAD_W-1:0]    i_radius,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  spct_pkg::t_setup              i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output spct_pkg::t_prod               o_data
);
    import spct_pkg::*;

    logic  r_valid;
    t_prod r_data;
    t_prod n_data;

    always_comb begin
        n_data.px       = i_data.px;
        n_data.py       = i_data.py;
        n_data.kind     = i_data.kind;
        n_data.box_ok   = i_data.box_ok;
        n_data.rect_hit = i_data.rect_hit;
        n_data.p0a = EP_W'($signed(i_data.e0.ex)) * EP_W'($signed(i_data.e0.qy));
        n_data.p0b = EP_W'($signed(i_data.e0.ey)) * EP_W'($signed(i_data.e0.qx));
        n_data.p1a = EP_W'($signed(i_data.e1.ex)) * EP_W'($signed(i_data.e1.qy));
        n_data.p1b = EP_W'($signed(i_data.e1.ey)) * EP_W'($signed(i_data.e1.qx));
        n_data.p2a = EP_W'($signed(i_data.e2.ex)) * EP_W'($signed(i_data.e2.qy));
        n_data.p2b = EP_W'($signed(i_data.e2.ey)) * EP_W'($signed(i_data.e2.qx));
        // Edge 1 operands are pixel minus vertex_a: the circle offsets.
        n_data.dx2 = $unsigned(SQ_W'($signed(i_data.e1.qx)) * SQ_W'($signed(i_data.e1.qx)));
        n_data.dy2 = $unsigned(SQ_W'($signed(i_data.e1.qy)) * SQ_W'($signed(i_data.e1.qy)));
        n_data.r2  = R2_W'(i_radius) * R2_W'(i_radius);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

[rtl/core/spct_eval.sv]
// ----------------------------------------------------------------------------
// Shape pixel coverage test - evaluate stages
// Sum edge products and distance, then decide coverage into the output register.
// ----------------------------------------------------------------------------
module spct_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  spct_pkg::t_prod   i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output spct_pkg::t_result o_data
);
    import spct_pkg::*;

    logic    r_vc, r_vd;
    logic    rdy_c, rdy_d;
    t_edge   r_c;
    t_edge   n_c;
    t_result r_d;
    t_result n_d;

    logic [DS_W-1:0]        dist_sq;
    logic signed [ES_W-1:0] s, t, d;
    logic signed [ST_W-1:0] st;
    logic                   tri_out, tri_hit, hit;

    // Edge sums and circle distance.
    always_comb begin
        n_c.px       = i_data.px;
        n_c.py       = i_data.py;
        n_c.kind     = i_data.kind;
        n_c.box_ok   = i_data.box_ok;
        n_c.rect_hit = i_data.rect_hit;
        n_c.s        = ES_W'(i_data.p0a) - ES_W'(i_data.p0b);
        n_c.t        = ES_W'(i_data.p1a) - ES_W'(i_data.p1b);
        n_c.d        = ES_W'(i_data.p2a) - ES_W'(i_data.p2b);
        dist_sq      = DS_W'(i_data.dx2) + DS_W'(i_data.dy2);
        n_c.circ_hit = dist_sq <= DS_W'(i_data.r2);
    end

    // Sign tests; an edge value of zero counts as inside.
    always_comb begin
        s       = r_c.s;
        t       = r_c.t;
        d       = r_c.d;
        st      = ST_W'(s) + ST_W'(t);
        tri_out = ((s < 0) != (t < 0)) && (s != 0) && (t != 0);
        tri_hit = !tri_out && ((d == 0) || ((d < 0) == (st <= 0)));
        case (r_c.kind)
            KIND_TRI:    hit = tri_hit;
            KIND_CIRCLE: hit = r_c.circ_hit;
            KIND_RECT:   hit = r_c.rect_hit;
            default:     hit = 1'b0;
        endcase
        n_d.we = hit && r_c.box_ok;
        n_d.px = r_c.px;
        n_d.py = r_c.py;
    end

    assign rdy_d   = !r_vd || i_ready;
    assign rdy_c   = !r_vc || rdy_d;
    assign o_ready = rdy_c;
    assign o_valid = r_vd;
    assign o_data  = r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_c) begin
                r_vc <= i_valid;
            end
            if (rdy_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c && i_valid) begin
            r_c <= n_c;
        end
        if (rdy_d && r_vc) begin
            r_d <= n_d;
        end
    end

endmodule

[rtl/core/shape_pixel_coverage_test_unit.sv]
// ----------------------------------------------------------------------------
// Shape pixel coverage test unit
// Tests pixel coordinates against one configured triangle, circle or rectangle.
// ----------------------------------------------------------------------------
// Feed one pixel coordinate per transfer on the slave stream; each one comes
// back on the master stream, in order, with a write enable and the fill color.
// The unit takes a new pixel every cycle while the master side keeps up, and each
// result comes out after a pipeline latency: four register stages (setup
// of box and edge operands, the multipliers, the edge and distance sums, the
// coverage decision into the output register) set that latency. Each stage
// holds its item on its own when the next one is full, so bubbles close up and
// the slave side keeps taking pixels while a result waits in the output
// register. Write the configuration port only while no pixel is in flight;
// writes are always accepted, and indexes past the last register
// are dropped. Vertices hold x in the upper and y in the lower COORD_BITS
// bits, both two's complement. A pixel is painted when it lies in the shape's
// bounding box (low edges in, high edges out), inside the image, and passes
// the shape test: edge functions for a triangle (edges count as inside),
// squared distance for a circle, strict interior for a rectangle. An unused
// shape code paints nothing.
// ----------------------------------------------------------------------------
`include "shape_pixel_coverage_test_unit_defines.svh"

module shape_pixel_coverage_test_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [spct_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [spct_pkg::CFG_DW-1:0]           i_cfg_data,
    // Pixel stream in
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata from bit 0: pixel_x[10:0], pixel_y[21:11], zero pad
    input  logic [spct_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // Result stream out
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tdata from bit 0: out_x[10:0], out_y[21:11], red[29:22], green[37:30],
    // blue[45:38], zero pad
    output logic [spct_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // tuser: write_enable
    output logic                                  o_m_axis_tuser
);
    import spct_pkg::*;

    t_cfg    w_cfg;
    t_setup  w_setup;
    t_prod   w_prod;
    t_result w_res;
    logic    w_setup_valid, w_setup_ready;
    logic    w_prod_valid, w_prod_ready;

    spct_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // Stage 1: box, clip, rectangle test and edge operands.
    spct_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_px    (i_s_axis_tdata[PIX_W-1:0]),
        .i_py    (i_s_axis_tdata[2*PIX_W-1:PIX_W]),
        .o_valid (w_setup_valid),
        .i_ready (w_setup_ready),
        .o_data  (w_setup)
    );

    // Stage 2: products.
    spct_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_radius (w_cfg.radius),
        .i_valid  (w_setup_valid),
        .o_ready  (w_setup_ready),
        .i_data   (w_setup),
        .o_valid  (w_prod_valid),
        .i_ready  (w_prod_ready),
        .o_data   (w_prod)
    );

    // Stages 3 and 4: sums, then the decision into the output register.
    spct_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prod_valid),
        .o_ready (w_prod_ready),
        .i_data  (w_prod),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_res)
    );

    // Color comes straight from the register; the user must change it only while idle, the block does not enforce this.
    assign o_m_axis_tdata = {{(OUT_TDATA_W - 2 * PIX_W - COL_W){1'b0}},
                             w_cfg.fill_color[CH_W-1:0],
                             w_cfg.fill_color[2*CH_W-1:CH_W],
                             w_cfg.fill_color[3*CH_W-1:2*CH_W],
                             w_res.py,
                             w_res.px};
    assign o_m_axis_tuser = w_res.we;

    // A painted pixel lies inside the image.
    `SPCT_ASSERT_IMPLIES(a_we_in_image, o_m_axis_tvalid && w_res.we, (IMG_W'(w_res.px) < w_cfg.image_width) && (IMG_W'(w_res.py) < w_cfg.image_height), "painted pixel outside image")

    // Only a defined shape code paints.
    `SPCT_ASSERT_IMPLIES(a_we_known_kind, o_m_axis_tvalid && w_res.we, (w_cfg.shape_kind == KIND_TRI) || (w_cfg.shape_kind == KIND_CIRCLE) || (w_cfg.shape_kind == KIND_RECT), "unused shape code painted")

    // Output color tracks the fill register.
    `SPCT_ASSERT_IMPLIES(a_color_match, o_m_axis_tvalid, o_m_axis_tdata[2*PIX_W+COL_W-1:2*PIX_W] == {w_cfg.fill_color[CH_W-1:0], w_cfg.fill_color[2*CH_W-1:CH_W], w_cfg.fill_color[3*CH_W-1:2*CH_W]}, "output color differs from fill register")

    // An image width write lands in the next cycle.
    `SPCT_ASSERT_NEXT(a_width_write, i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_IMAGE_WIDTH), w_cfg.image_width == $past(i_cfg_data[IMG_W-1:0]), "image width write lost")

endmodule
